// ===== hdl/owm_pkg.sv =====
// Package with the shared types, codes and timing constants of the 1-Wire bus master.
`timescale 1ns / 1ps
package owm_pkg;

    // Request kinds on the input channel; operation codes reuse them.
    localparam logic [2:0] REQ_TICK  = 3'd0;
    localparam logic [2:0] REQ_RESET = 3'd1;
    localparam logic [2:0] REQ_WBYTE = 3'd2;
    localparam logic [2:0] REQ_RBYTE = 3'd3;
    localparam logic [2:0] REQ_WBIT  = 3'd4;
    localparam logic [2:0] REQ_RBIT  = 3'd5;
    localparam logic [2:0] OP_IDLE   = 3'd0;

    // Slot phases.
    localparam logic [1:0] PH_LOW   = 2'd0;
    localparam logic [1:0] PH_REL1  = 2'd1;
    localparam logic [1:0] PH_REL2  = 2'd2;

    // Slot timings in microseconds.
    localparam logic [8:0] T_RST_LOW   = 9'd480;
    localparam logic [8:0] T_RST_SMP   = 9'd70;
    localparam logic [8:0] T_RST_REST  = 9'd410;
    localparam logic [8:0] T_W1_LOW    = 9'd6;
    localparam logic [8:0] T_W1_REL    = 9'd64;
    localparam logic [8:0] T_W0_LOW    = 9'd60;
    localparam logic [8:0] T_W0_REL    = 9'd10;
    localparam logic [8:0] T_RD_LOW    = 9'd2;
    localparam logic [8:0] T_RD_SMP    = 9'd10;
    localparam logic [8:0] T_RD_REST   = 9'd50;

    localparam logic [7:0] CPU_RESET   = 8'd72;

    // Bit positions of the result fields in m_tdata.
    localparam int unsigned OUT_DRIVE  = 0;
    localparam int unsigned OUT_BUSY   = 1;
    localparam int unsigned OUT_DONE   = 2;
    localparam int unsigned OUT_RD_LSB = 3;
    localparam int unsigned OUT_PRES   = 11;
    localparam int unsigned OUT_REJ    = 12;

    typedef struct packed {
        logic [2:0] op;
        logic [1:0] phase;
        logic [8:0] us_cnt;
        logic [7:0] pre_cnt;
        logic [3:0] bit_pos;
        logic [7:0] shift;
        logic       pres_seen;
    } owm_state_t;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] write_data;
        logic       bus_level;
    } owm_item_t;

    typedef struct packed {
        logic       rejected;
        logic       presence;
        logic [7:0] read_data;
        logic       done_res;
        logic       busy_res;
        logic       drive_low;
    } owm_result_t;

    // Length of the current phase in microseconds.
    function automatic logic [8:0] phase_length(input owm_state_t st);
        logic b;
        b = st.shift[0];
        case (st.op)
            REQ_RESET: phase_length = (st.phase == PH_LOW)  ? T_RST_LOW :
                                      (st.phase == PH_REL1) ? T_RST_SMP : T_RST_REST;
            REQ_WBYTE, REQ_WBIT: begin
                if (st.phase == PH_LOW) begin
                    phase_length = b ? T_W1_LOW : T_W0_LOW;
                end else begin
                    phase_length = b ? T_W1_REL : T_W0_REL;
                end
            end
            default: phase_length = (st.phase == PH_LOW)  ? T_RD_LOW :
                                    (st.phase == PH_REL1) ? T_RD_SMP : T_RD_REST;
        endcase
    endfunction

endpackage

// ===== hdl/owm_step.sv =====
// Next-state and result logic for one request of the 1-Wire bus master.
`timescale 1ns / 1ps
module owm_step (
    input  owm_pkg::owm_state_t  cur,
    input  owm_pkg::owm_item_t   item,
    input  logic [7:0]           cycles_per_us,
    output owm_pkg::owm_state_t  nxt,
    output owm_pkg::owm_result_t res
);
    import owm_pkg::*;

    logic       is_cmd;
    logic [7:0] cpu;
    logic [7:0] pre_inc;
    logic [8:0] us_inc;
    logic [8:0] plen;
    logic [3:0] bit_inc;
    logic [3:0] nbits;
    logic       is_read;
    logic       is_write;
    logic       done;
    logic [7:0] rdata;
    logic       pres;
    logic       rej;

    always_comb begin
        is_cmd   = (item.req_type == REQ_RESET) || (item.req_type == REQ_WBYTE) ||
                   (item.req_type == REQ_RBYTE) || (item.req_type == REQ_WBIT)  ||
                   (item.req_type == REQ_RBIT);
        cpu      = (cycles_per_us == 8'd0) ? 8'd1 : cycles_per_us;
        pre_inc  = cur.pre_cnt + 8'd1;
        us_inc   = cur.us_cnt + 9'd1;
        plen     = phase_length(cur);
        bit_inc  = cur.bit_pos + 4'd1;
        is_read  = (cur.op == REQ_RBYTE) || (cur.op == REQ_RBIT);
        is_write = (cur.op == REQ_WBYTE) || (cur.op == REQ_WBIT);
        nbits    = ((cur.op == REQ_WBYTE) || (cur.op == REQ_RBYTE)) ? 4'd8 : 4'd1;

        nxt   = cur;
        done  = 1'b0;
        rdata = 8'd0;
        pres  = 1'b0;
        rej   = 1'b0;

        if (is_cmd) begin
            if (cur.op != OP_IDLE) begin
                rej = 1'b1;
            end else begin
                nxt.op        = item.req_type;
                nxt.phase     = PH_LOW;
                nxt.us_cnt    = 9'd0;
                nxt.pre_cnt   = 8'd0;
                nxt.bit_pos   = 4'd0;
                nxt.pres_seen = 1'b0;
                nxt.shift     = (item.req_type == REQ_WBIT)  ? {7'd0, item.write_data[0]} :
                                (item.req_type == REQ_WBYTE) ? item.write_data : 8'd0;
            end
        end else if ((item.req_type == REQ_TICK) && (cur.op != OP_IDLE)) begin
            if (pre_inc < cpu) begin
                nxt.pre_cnt = pre_inc;
            end else begin
                nxt.pre_cnt = 8'd0;
                if (us_inc < plen) begin
                    nxt.us_cnt = us_inc;
                end else begin
                    nxt.us_cnt = 9'd0;
                    if (cur.phase == PH_LOW) begin
                        nxt.phase = PH_REL1;
                    end else if (cur.op == REQ_RESET) begin
                        if (cur.phase == PH_REL1) begin
                            nxt.pres_seen = ~item.bus_level;
                            nxt.phase     = PH_REL2;
                        end else begin
                            nxt.op    = OP_IDLE;
                            nxt.phase = PH_LOW;
                            done      = 1'b1;
                            pres      = cur.pres_seen;
                        end
                    end else if (is_read && (cur.phase == PH_REL1)) begin
                        // Sample on the tick that closes the first release part.
                        if (cur.op == REQ_RBIT) begin
                            nxt.shift = {7'd0, item.bus_level};
                        end else begin
                            nxt.shift = {item.bus_level, cur.shift[7:1]};
                        end
                        nxt.phase = PH_REL2;
                    end else begin
                        // End of one bit slot.
                        if (is_write) begin
                            nxt.shift = {1'b0, cur.shift[7:1]};
                        end
                        nxt.bit_pos = bit_inc;
                        nxt.phase   = PH_LOW;
                        if (bit_inc >= nbits) begin
                            rdata  = is_read ? cur.shift : 8'd0;
                            nxt.op = OP_IDLE;
                            done   = 1'b1;
                        end
                    end
                end
            end
        end

        res.drive_low = (nxt.op != OP_IDLE) && (nxt.phase == PH_LOW);
        res.busy_res  = (nxt.op != OP_IDLE);
        res.done_res  = done;
        res.read_data = rdata;
        res.presence  = pres;
        res.rejected  = rej;
    end

endmodule

// ===== hdl/onewire_bus_master.sv =====
// Top level of the 1-Wire bus master: request register, sequencer state and result register.
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake            Contents
//  s_        in         s_tvalid/s_tready    tick with bus level, or a command
//  m_        out        m_tvalid/m_tready    status and data, one per request
//  cfg_      in         cfg_valid/cfg_ready  cycles_per_us prescaler
//
//  A request is taken every cycle while the result side keeps up; its result
//  passes through the request register, then the result register, before it
//  is offered.
//  The sequencer state is updated in the same cycle the result register loads.
//  A stall on m_tready holds the result and the request register, and s_tready
//  drops only when both are full. Reset clears the sequencer to idle and sets
//  cycles_per_us to 72.
//
module onewire_bus_master (
    input  logic        aclk,
    input  logic        aresetn,
    // Requests.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] write_data, [8] bus_level, [15:9] zero
    input  logic [2:0]  s_tuser,   // [2:0] req_type
    // Results.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [0] drive_low, [1] busy_res, [2] done_res,
                                   // [10:3] read_data, [11] presence, [12] rejected,
                                   // [15:13] zero
    // Prescaler setting.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);
    import owm_pkg::*;

    logic        in_valid_reg;
    owm_item_t   in_item_reg;
    logic        out_valid_reg;
    owm_result_t out_res_reg;
    owm_state_t  state_reg;
    owm_state_t  state_next;
    owm_result_t res_next;
    logic [7:0]  cpu_reg;
    logic        advance;

    // The request register moves into the result register whenever that
    // register is empty or being drained this cycle.
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cpu_reg <= CPU_RESET;
        end else if (cfg_valid && cfg_ready) begin
            cpu_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.req_type   <= s_tuser;
            in_item_reg.write_data <= s_tdata[7:0];
            in_item_reg.bus_level  <= s_tdata[8];
        end
    end

    owm_step u_step (
        .cur           (state_reg),
        .item          (in_item_reg),
        .cycles_per_us (cpu_reg),
        .nxt           (state_next),
        .res           (res_next)
    );

    // Sequencer state changes only when a request is actually processed.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0, out_res_reg.rejected, out_res_reg.presence,
                       out_res_reg.read_data, out_res_reg.done_res,
                       out_res_reg.busy_res, out_res_reg.drive_low};

endmodule

// ===== hdl/owm_checker.sv =====
// Port-level checks for the 1-Wire bus master and the bind that attaches them.
`timescale 1ns / 1ps
module owm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);
    import owm_pkg::*;

    // A result held back by the sink stays and keeps its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");

    // The bus is only pulled low while a command is in progress.
    a_drive_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[OUT_DRIVE]) |-> m_tdata[OUT_BUSY])
        else $error("bus driven low while idle");

    // A completing command leaves the sequencer idle and the bus released.
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[OUT_DONE]) |-> (!m_tdata[OUT_BUSY] && !m_tdata[OUT_DRIVE]))
        else $error("done reported while still busy");

    // A rejection happens only while busy and never coincides with completion.
    a_reject_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[OUT_REJ]) |-> (m_tdata[OUT_BUSY] && !m_tdata[OUT_DONE]))
        else $error("rejection while idle or on completion");

    // Presence and read data are reported only with a completion.
    a_data_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[OUT_DONE]) |->
            (!m_tdata[OUT_PRES] && (m_tdata[OUT_RD_LSB +: 8] == 8'd0)))
        else $error("result data outside a completion");

endmodule

bind onewire_bus_master owm_checker u_owm_checker (.*);

// ===== test/owm_result_check.sv =====
// Result checker for the 1-Wire bus master: predicts every result and compares it.
`timescale 1ns / 1ps
module owm_result_check (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic [2:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    output int          mismatch_count,
    output int          results_owed,
    output logic        line_idle
);
    import owm_pkg::*;

    // Predicted sequencer state.
    logic [7:0] prescale_set;
    logic [2:0] cur_op;
    logic [1:0] cur_phase;
    logic [8:0] us_count;
    logic [7:0] tick_count;
    logic [3:0] bits_done;
    logic [7:0] shift_reg;
    logic       pres_flag;

    owm_result_t expected_status[$];

    // Microseconds that the given part of a slot lasts.
    function automatic logic [8:0] slot_length(input logic [2:0] op, input logic [1:0] ph,
                                               input logic one);
        case (op)
            REQ_RESET: begin
                if (ph == PH_LOW) return T_RST_LOW;
                if (ph == PH_REL1) return T_RST_SMP;
                return T_RST_REST;
            end
            REQ_WBYTE, REQ_WBIT: begin
                if (ph == PH_LOW) return one ? T_W1_LOW : T_W0_LOW;
                return one ? T_W1_REL : T_W0_REL;
            end
            default: begin
                if (ph == PH_LOW) return T_RD_LOW;
                if (ph == PH_REL1) return T_RD_SMP;
                return T_RD_REST;
            end
        endcase
    endfunction

    // Advances the predicted state by one request and gives its status word.
    task automatic step_request(input logic [2:0] req, input logic [7:0] wdata,
                                input logic level, output owm_result_t res);
        logic [7:0] rate;
        logic       byte_op;
        logic       read_op;
        res = '0;
        if (req >= REQ_RESET && req <= REQ_RBIT) begin
            if (cur_op != OP_IDLE) begin
                res.rejected = 1'b1;
            end else begin
                cur_op     = req;
                cur_phase  = PH_LOW;
                us_count   = '0;
                tick_count = '0;
                bits_done  = '0;
                pres_flag  = 1'b0;
                if (req == REQ_WBIT) begin
                    shift_reg = {7'd0, wdata[0]};
                end else if (req == REQ_WBYTE) begin
                    shift_reg = wdata;
                end else begin
                    shift_reg = 8'd0;
                end
            end
        end else if (req == REQ_TICK && cur_op != OP_IDLE) begin
            rate = (prescale_set == 8'd0) ? 8'd1 : prescale_set;
            tick_count = tick_count + 8'd1;
            if (tick_count >= rate) begin
                tick_count = '0;
                us_count = us_count + 9'd1;
                if (us_count >= slot_length(cur_op, cur_phase, shift_reg[0])) begin
                    us_count = '0;
                    byte_op = (cur_op == REQ_WBYTE) || (cur_op == REQ_RBYTE);
                    read_op = (cur_op == REQ_RBYTE) || (cur_op == REQ_RBIT);
                    if (cur_phase == PH_LOW) begin
                        cur_phase = PH_REL1;
                    end else if (cur_op == REQ_RESET) begin
                        if (cur_phase == PH_REL1) begin
                            // A device answering the reset holds the line low here.
                            pres_flag = ~level;
                            cur_phase = PH_REL2;
                        end else begin
                            res.done_res = 1'b1;
                            res.presence = pres_flag;
                            cur_op       = OP_IDLE;
                            cur_phase    = PH_LOW;
                        end
                    end else if (read_op && cur_phase == PH_REL1) begin
                        if (cur_op == REQ_RBIT) begin
                            shift_reg = {7'd0, level};
                        end else begin
                            shift_reg = {level, shift_reg[7:1]};
                        end
                        cur_phase = PH_REL2;
                    end else begin
                        if (!read_op) begin
                            shift_reg = shift_reg >> 1;
                        end
                        bits_done = bits_done + 4'd1;
                        if (bits_done >= (byte_op ? 4'd8 : 4'd1)) begin
                            res.done_res  = 1'b1;
                            res.read_data = read_op ? shift_reg : 8'd0;
                            cur_op        = OP_IDLE;
                        end
                        cur_phase = PH_LOW;
                    end
                end
            end
        end
        res.busy_res  = (cur_op != OP_IDLE);
        res.drive_low = (cur_op != OP_IDLE) && (cur_phase == PH_LOW);
    endtask

    always @(posedge aclk) begin : track
        owm_result_t want;
        owm_result_t got;
        if (!aresetn) begin
            prescale_set   = CPU_RESET;
            cur_op         = OP_IDLE;
            cur_phase      = PH_LOW;
            us_count       = '0;
            tick_count     = '0;
            bits_done      = '0;
            shift_reg      = '0;
            pres_flag      = 1'b0;
            mismatch_count = 0;
            expected_status.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                prescale_set = cfg_data;
            end
            if (s_tvalid && s_tready) begin
                step_request(s_tuser, s_tdata[7:0], s_tdata[8], want);
                expected_status.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[12:0];
                if (expected_status.size() == 0) begin
                    $display("%0t: result expected none, actual %h", $time, m_tdata);
                    mismatch_count++;
                end else begin
                    want = expected_status.pop_front();
                    if (want != got) begin
                        // Fields from the top: rejected, presence, read_data,
                        // done, busy, drive_low.
                        $display("%0t: result expected %h, actual %h", $time, want, got);
                        mismatch_count++;
                    end
                end
            end
        end
        results_owed = expected_status.size();
        line_idle    = (cur_op == OP_IDLE);
    end

endmodule

// ===== test/testbench.sv =====
// Top of the 1-Wire bus master testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
    import owm_pkg::*;

    // Request codes that the block must treat as no operation.
    localparam logic [2:0] REQ_RSVD6 = 3'd6;
    localparam logic [2:0] REQ_RSVD7 = 3'd7;

    // How the bus level is driven on the ticks that finish a command.
    localparam int LEVEL_LOW    = 0;
    localparam int LEVEL_HIGH   = 1;
    localparam int LEVEL_RANDOM = 2;

    // Ticks given at the reset prescaler; enough to end the first low part
    // of a read slot. The closing stretch has a fixed length and is not
    // run out, so the total stays near the planned request count.
    localparam int SLOW_TICKS = 150;
    localparam int TAIL_ITEMS = 150;

    // Cycles without any request, result or register write before giving up.
    localparam int QUIET_LIMIT = 400;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic [2:0]  s_tuser   = REQ_TICK;
    logic        m_tvalid;
    logic        m_tready  = 1'b1;
    logic [15:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data  = '0;

    int   mismatch_count;
    int   results_owed;
    logic line_idle;

    // Random stalls on both sides are enabled only while this is set.
    logic idle_on = 1'b0;
    int   items_sent = 0;
    int   stall_left = 0;
    int   quiet_cycles = 0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    onewire_bus_master dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    owm_result_check result_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed),
        .line_idle      (line_idle)
    );

    // The result side stalls in bursts that hold m_tready low. Once a burst
    // ends a new one may start right away, so back-to-back stalls also occur.
    always @(negedge aclk) begin
        if (!idle_on) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if ($urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(0, 6);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // The watchdog restarts on every handshake of any channel, so it only
    // trips when the block stops taking requests or stops returning results.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Verification failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // All stimulus tasks are entered right after a falling edge and return
    // right after one. Decisions that read the predicted sequencer state are
    // therefore made at a falling edge, after the checker has updated it.

    // Presents one request and waits until the block has taken it. With
    // stalls enabled, a gap with s_tvalid low may come first.
    task automatic push(input logic [2:0] kind, input logic [7:0] data, input logic level);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 7)) begin
                s_tvalid <= 1'b0;
                @(negedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {7'd0, level, data};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        @(negedge aclk);
        items_sent++;
    endtask

    // Feeds ticks until the predicted sequencer has finished its command.
    // Only the ticks that end a sample window matter for the level, but all
    // of them follow the chosen mode so the sample point needs no tracking.
    task automatic run_out(input int mode);
        logic lv;
        while (!line_idle) begin
            lv = (mode == LEVEL_RANDOM) ? 1'($urandom_range(0, 1)) : (mode == LEVEL_HIGH);
            push(REQ_TICK, 8'($urandom_range(0, 255)), lv);
        end
    endtask

    // Issues one command and runs it to completion.
    task automatic command(input logic [2:0] kind, input logic [7:0] data, input int mode);
        push(kind, data, 1'($urandom_range(0, 1)));
        run_out(mode);
    endtask

    // Writes the prescaler once every outstanding result has come back.
    task automatic set_rate(input logic [7:0] value);
        s_tvalid <= 1'b0;
        while (results_owed != 0) begin
            @(negedge aclk);
        end
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Bit commands are favored: they finish fastest, so more of them
    // complete per tick than byte commands or bus resets.
    function automatic logic [2:0] random_command();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return REQ_RESET;
        if (pick <= 2) return REQ_WBYTE;
        if (pick <= 4) return REQ_RBYTE;
        if (pick <= 7) return REQ_WBIT;
        return REQ_RBIT;
    endfunction

    // A random stretch: while idle, mostly new commands; while busy, mostly
    // ticks with the odd command that must be rejected and the odd reserved
    // code.
    task automatic random_stretch(input int count);
        int pick;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (line_idle) begin
                if (pick < 80) begin
                    push(random_command(), 8'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)));
                end else if (pick < 92) begin
                    push(REQ_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                end else begin
                    push($urandom_range(0, 1) ? REQ_RSVD6 : REQ_RSVD7,
                         8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                end
            end else begin
                if (pick < 94) begin
                    push(REQ_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                end else if (pick < 97) begin
                    push(random_command(), 8'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)));
                end else begin
                    push($urandom_range(0, 1) ? REQ_RSVD6 : REQ_RSVD7,
                         8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                end
            end
        end
    endtask

    initial begin
        int i;

        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        idle_on = 1'b1;

        // Reserved codes and ticks while idle change nothing. Then a read bit
        // at the reset prescaler, with commands and a reserved code arriving
        // while it is busy; those commands must be rejected.
        push(REQ_TICK, 8'h00, 1'b0);
        push(REQ_RSVD6, 8'hFF, 1'b1);
        push(REQ_RBIT, 8'h00, 1'b0);
        for (i = 0; i < SLOW_TICKS; i++) begin
            if (i == 20) begin
                push(REQ_WBYTE, 8'h5A, 1'b1);
            end
            if (i == 60) begin
                push(REQ_RSVD7, 8'hA5, 1'b0);
            end
            if (i == 100) begin
                push(REQ_RESET, 8'hFF, 1'b1);
            end
            push(REQ_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end

        // A zero prescaler counts as one tick per microsecond; the read bit
        // finishes under it.
        set_rate(8'd0);
        run_out(LEVEL_HIGH);

        // Both write-bit slot shapes, a read bit, and a full read byte.
        command(REQ_WBIT, 8'hFE, LEVEL_RANDOM);
        command(REQ_WBIT, 8'h01, LEVEL_RANDOM);
        command(REQ_RBIT, 8'hFF, LEVEL_LOW);
        command(REQ_RBYTE, 8'h00, LEVEL_RANDOM);

        // Closing stretch at full rate on both sides.
        idle_on = 1'b0;
        set_rate(8'd1);
        random_stretch(TAIL_ITEMS);

        s_tvalid <= 1'b0;
        while (results_owed != 0) begin
            @(negedge aclk);
        end
        repeat (8) @(negedge aclk);

        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/owm_pkg.sv
hdl/owm_step.sv
hdl/onewire_bus_master.sv
hdl/owm_checker.sv
test/owm_result_check.sv
test/testbench.sv
